// File: rtl/core/tlsq_pkg.sv
// ----------------------------------------------------------------------------
// tlsq_pkg
// Shared types and codes for the two-lane shortest-queue dispatcher.
// ----------------------------------------------------------------------------
package tlsq_pkg;

  // default sizes
  localparam int LANE_DEPTH_DEF = 16;
  localparam int ID_WIDTH_DEF   = 32;

  // op codes
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_SERVE = 2'd1;
  localparam logic [1:0] OP_LOOK  = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // command beat
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] customer_id;
  } cmd_t;

  // result beat
  typedef struct packed {
    logic [1:0]  status;
    logic        lane;
    logic [31:0] served_id;
    logic [4:0]  lane_one_count;
    logic [4:0]  lane_two_count;
    logic        next_valid;
    logic [31:0] next_id;
  } result_t;

  // per-lane ring control
  typedef struct packed {
    logic push;
    logic pop;
    logic peek;
  } lane_ctl_t;

endpackage

// File: rtl/core/tlsq_lane.sv
// ----------------------------------------------------------------------------
// tlsq_lane
// One FIFO ring of ids: synchronous memory with head index and fill count.
// Pop and peek read the head entry; rd_data is registered and shows it in the next cycle.
// ----------------------------------------------------------------------------
module tlsq_lane
  import tlsq_pkg::*;
#(
  parameter int LANE_DEPTH = LANE_DEPTH_DEF,
  parameter int ID_WIDTH   = ID_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lane_ctl_t                       ctl,
  input  logic [ID_WIDTH-1:0]             push_data,
  output logic [ID_WIDTH-1:0]             rd_data,
  output logic [$clog2(LANE_DEPTH+1)-1:0] fill
);

  localparam int IDX_W  = $clog2(LANE_DEPTH);
  localparam int FILL_W = $clog2(LANE_DEPTH + 1);
  localparam int SUM_W  = FILL_W + 1;

  logic [ID_WIDTH-1:0] mem [LANE_DEPTH];
  logic [IDX_W-1:0]    head;
  logic [IDX_W-1:0]    head_next;
  logic [SUM_W-1:0]    tail_sum;
  logic [SUM_W-1:0]    tail_wrap;
  logic [IDX_W-1:0]    tail;

  // tail slot: head plus fill, wrapped once
  always_comb begin
    tail_sum  = SUM_W'(head) + SUM_W'(fill);
    tail_wrap = (tail_sum >= SUM_W'(LANE_DEPTH)) ? tail_sum - SUM_W'(LANE_DEPTH) : tail_sum;
    tail      = tail_wrap[IDX_W-1:0];
  end

  // head advance with wrap
  always_comb begin
    if (head == IDX_W'(LANE_DEPTH - 1)) begin
      head_next = '0;
    end else begin
      head_next = head + IDX_W'(1);
    end
  end

  // ring memory
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= push_data;
    end
    if (ctl.pop || ctl.peek) begin
      rd_data <= mem[head];
    end
  end

  // head and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else begin
      if (ctl.push) begin
        fill <= fill + FILL_W'(1);
      end else if (ctl.pop) begin
        fill <= fill - FILL_W'(1);
        head <= head_next;
      end
    end
  end

endmodule

// File: rtl/core/two_lane_shortest_queue_dispatch.sv
// ----------------------------------------------------------------------------
// two_lane_shortest_queue_dispatch
// Join-shortest-queue dispatcher over two FIFO rings of customer ids.
//
//   channel  | ports                 | handshake
//   ---------+-----------------------+-----------------------------------
//   command  | start, busy, cmd      | beat taken when start && !busy
//   result   | strobe, result        | one beat, valid for one cycle only
//
// Each command passes from accept through S_PEEK and S_RESP; strobe is registered
// from S_RESP. busy is high in S_PEEK and S_RESP, set by the two ring memory
// reads (served entry, then the new head). A new command may be accepted in the
// strobe cycle. Synchronous reset empties both rings; ring contents are not cleared.
// The result side has no back-pressure.
// ----------------------------------------------------------------------------
module two_lane_shortest_queue_dispatch
  import tlsq_pkg::*;
#(
  parameter int LANE_DEPTH = LANE_DEPTH_DEF,
  parameter int ID_WIDTH   = ID_WIDTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    strobe,
  output result_t result
);

  localparam int FILL_W = $clog2(LANE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PEEK = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t              state;
  lane_ctl_t           ctl_one;
  lane_ctl_t           ctl_two;
  logic [ID_WIDTH-1:0] push_data;
  logic [ID_WIDTH-1:0] rd_one;
  logic [ID_WIDTH-1:0] rd_two;
  logic [FILL_W-1:0]   fill_one;
  logic [FILL_W-1:0]   fill_two;
  logic                accept;
  logic                pick_two;
  logic                chosen_full;

  // registers of the item in flight
  logic [1:0]          status_q;
  logic                lane_q;
  logic                pop_q;
  logic [ID_WIDTH-1:0] served_q;
  logic                peek_two_q;
  logic                next_valid_q;
  logic [1:0]          status_next;
  logic                lane_next;

  tlsq_lane #(.LANE_DEPTH(LANE_DEPTH), .ID_WIDTH(ID_WIDTH)) u_lane_one (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl_one),
    .push_data (push_data),
    .rd_data   (rd_one),
    .fill      (fill_one)
  );

  tlsq_lane #(.LANE_DEPTH(LANE_DEPTH), .ID_WIDTH(ID_WIDTH)) u_lane_two (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl_two),
    .push_data (push_data),
    .rd_data   (rd_two),
    .fill      (fill_two)
  );

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign push_data = ID_WIDTH'(cmd.customer_id);

  // lane choice for add: shorter lane, ties to lane one
  assign pick_two    = (fill_one > fill_two);
  assign chosen_full = pick_two ? (fill_two == FILL_W'(LANE_DEPTH))
                                : (fill_one == FILL_W'(LANE_DEPTH));

  // ring control and decision
  always_comb begin
    ctl_one     = '0;
    ctl_two     = '0;
    status_next = ST_DONE;
    lane_next   = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd.op)
            OP_ADD: begin
              lane_next = pick_two;
              if (chosen_full) begin
                status_next = ST_FULL;
              end else if (pick_two) begin
                ctl_two.push = 1'b1;
              end else begin
                ctl_one.push = 1'b1;
              end
            end
            OP_SERVE: begin
              if (fill_one != '0) begin
                ctl_one.pop = 1'b1;
              end else if (fill_two != '0) begin
                ctl_two.pop = 1'b1;
                lane_next   = 1'b1;
              end else begin
                status_next = ST_EMPTY;
              end
            end
            default: begin
              status_next = ST_DONE;
            end
          endcase
        end
      end
      S_PEEK: begin
        if (fill_one != '0) begin
          ctl_one.peek = 1'b1;
        end else if (fill_two != '0) begin
          ctl_two.peek = 1'b1;
        end
      end
      default: begin
        ctl_one = '0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= (state == S_RESP);
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_PEEK;
          end
        end
        S_PEEK: begin
          state <= S_RESP;
        end
        S_RESP: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // item payload through the steps
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          status_q <= status_next;
          lane_q   <= lane_next;
          pop_q    <= ctl_one.pop || ctl_two.pop;
        end
      end
      S_PEEK: begin
        served_q     <= pop_q ? (lane_q ? rd_two : rd_one) : '0;
        peek_two_q   <= (fill_one == '0);
        next_valid_q <= (fill_one != '0) || (fill_two != '0);
      end
      S_RESP: begin
        result.status         <= status_q;
        result.lane           <= lane_q;
        result.served_id      <= 32'(served_q);
        result.lane_one_count <= 5'(fill_one);
        result.lane_two_count <= 5'(fill_two);
        result.next_valid     <= next_valid_q;
        result.next_id        <= next_valid_q ? 32'(peek_two_q ? rd_two : rd_one) : '0;
      end
      default: begin
        served_q <= served_q;
      end
    endcase
  end

endmodule
